// ===== hdl/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types, style codes, character codes and character class functions
// for the template syntax lexer.
// ----------------------------------------------------------------------------
package tsl_pkg;

   // style codes
   localparam logic [2:0] ST_DEFAULT  = 3'd0;
   localparam logic [2:0] ST_OPERATOR = 3'd1;
   localparam logic [2:0] ST_IDENT    = 3'd2;
   localparam logic [2:0] ST_COMMENT  = 3'd3;
   localparam logic [2:0] ST_STRING   = 3'd4;
   localparam logic [2:0] ST_LITERAL  = 3'd5;
   localparam logic [2:0] ST_SPECIAL  = 3'd6;
   localparam logic [2:0] ST_FIELD    = 3'd7;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_STYLE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_INACTIVE = 2'd1;

   // character codes
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // lexer state carried from one item to the next
   typedef struct packed {
      logic [2:0] token_style;
      logic       token_inactive;
      logic       swallow_next;
      logic       line_start;
   } tsl_state_type;

   // one styled result
   typedef struct packed {
      logic [2:0] style;
      logic       inactive_mark;
   } tsl_result_type;

   // ascii letters, digits and underscore
   function automatic logic is_word(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA ||
             c == CH_LBRACK || c == CH_RBRACK;
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      return c == CH_DOLLAR || c == CH_PCT || c == CH_QUOTE;
   endfunction

   function automatic logic is_literal(input logic [7:0] c);
      return !is_special(c) && !is_op(c) && c != CH_CR && c != CH_LF;
   endfunction

endpackage

// ===== hdl/tsl_step.sv =====
// ----------------------------------------------------------------------------
// tsl_step
// Single-character styling decision: from the current lexer state and one
// character with its look-ahead, gives the character's style and the state
// for the following character.
// ----------------------------------------------------------------------------
module tsl_step import tsl_pkg::*; (
   input  tsl_state_type  state,
   input  logic [7:0]     ch,
   input  logic [7:0]     next_ch,
   input  logic           in_inactive,
   output tsl_state_type  state_next,
   output tsl_result_type result
);

   logic       closing;
   logic [2:0] cont_style;
   logic [2:0] start_style;

   // does the running token continue, end or close on this character
   always_comb begin
      closing    = 1'b0;
      cont_style = state.token_style;
      case (state.token_style)
         ST_OPERATOR, ST_SPECIAL: cont_style = ST_DEFAULT;
         ST_IDENT:   if (!is_word(ch)) cont_style = ST_DEFAULT;
         ST_COMMENT: if (state.line_start) cont_style = ST_DEFAULT;
         ST_STRING:  if (ch == CH_QUOTE) closing = 1'b1;
         ST_LITERAL: if (!is_literal(ch)) cont_style = ST_DEFAULT;
         ST_FIELD:   if (ch == CH_PCT) closing = 1'b1;
         default:    cont_style = state.token_style;
      endcase
   end

   // style of a token opened on this character (comment pair handled apart)
   always_comb begin
      if (is_op(ch)) begin
         start_style = ST_OPERATOR;
      end else if (is_special(ch) && ch == next_ch) begin
         start_style = ST_SPECIAL;
      end else if (ch == CH_DOLLAR) begin
         start_style = ST_IDENT;
      end else if (ch == CH_PCT) begin
         start_style = ST_FIELD;
      end else if (ch == CH_QUOTE) begin
         start_style = ST_STRING;
      end else if (is_literal(ch)) begin
         start_style = ST_LITERAL;
      end else begin
         start_style = ST_DEFAULT;
      end
   end

   // next state and result
   always_comb begin
      state_next = state;
      result.style         = state.token_style;
      result.inactive_mark = state.token_inactive;
      if (state.swallow_next) begin
         // second byte of a pair takes the current style unexamined
         state_next.swallow_next = 1'b0;
      end else if (closing) begin
         state_next.token_style    = ST_DEFAULT;
         state_next.token_inactive = 1'b0;
      end else if (cont_style == ST_DEFAULT) begin
         if (ch == CH_SLASH && next_ch == CH_SLASH) begin
            state_next.token_style    = ST_COMMENT;
            state_next.token_inactive = 1'b0;
            state_next.swallow_next   = 1'b1;
         end else begin
            state_next.token_style    = start_style;
            state_next.token_inactive = (start_style != ST_DEFAULT) ? in_inactive : 1'b0;
            state_next.swallow_next   = (start_style == ST_SPECIAL);
         end
         result.style         = state_next.token_style;
         result.inactive_mark = state_next.token_inactive;
      end else begin
         state_next.token_style = cont_style;
         result.style           = cont_style;
      end
      // line start after LF, or after a CR not followed by LF
      state_next.line_start = (ch == CH_LF) || (ch == CH_CR && next_ch != CH_LF);
   end

endmodule

// ===== hdl/template_syntax_lexer_core.sv =====
// ----------------------------------------------------------------------------
// template_syntax_lexer_core
// Per-character syntax styler for a template language: one style and
// inactive mark for every character item, with token state kept between
// items and a two-entry result buffer on the output side.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_ch, req_next_ch, req_in_inactive
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_style, rsp_inactive_mark
//  csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
//  one item per cycle while req_stall is low; each result is registered before it reaches rsp
//  the lexer state is updated at the accepting edge, so items chain freely
//  a result register plus a skid entry let one more item in while rsp stalls;
//  req_stall rises only when the skid entry is occupied
//  reset is synchronous; the state starts from the reset register values
// ----------------------------------------------------------------------------
module template_syntax_lexer_core import tsl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_ch,
   input  logic [7:0]                 req_next_ch,
   input  logic                       req_in_inactive,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_style,
   output logic                       rsp_inactive_mark,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [2:0]     start_style_ff,    start_style_in;
   logic           start_inactive_ff, start_inactive_in;
   tsl_state_type  state_ff,          state_in;
   tsl_state_type  step_state;
   tsl_result_type step_result;
   tsl_result_type rsp_ff,            rsp_in;
   tsl_result_type skid_ff,           skid_in;
   logic           rsp_valid_ff,      rsp_valid_in;
   logic           skid_valid_ff,     skid_valid_in;
   logic           req_take;
   logic           rsp_pop;
   logic           csr_hit;

   assign req_stall         = skid_valid_ff;
   assign req_take          = req_valid && !skid_valid_ff;
   assign rsp_pop           = rsp_valid_ff && !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_style         = rsp_ff.style;
   assign rsp_inactive_mark = rsp_ff.inactive_mark;
   assign csr_hit = csr_write_enable &&
                    (csr_index == CSR_START_STYLE || csr_index == CSR_START_INACTIVE);

   // per-character decision
   tsl_step u_step (
      .state       (state_ff),
      .ch          (req_ch),
      .next_ch     (req_next_ch),
      .in_inactive (req_in_inactive),
      .state_next  (step_state),
      .result      (step_result)
   );

   // configuration registers and lexer state
   always_comb begin
      start_style_in    = start_style_ff;
      start_inactive_in = start_inactive_ff;
      state_in          = state_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_STYLE:    start_style_in    = csr_write_data;
            CSR_START_INACTIVE: start_inactive_in = csr_write_data[0];
            default:            ;
         endcase
      end
      if (csr_hit) begin
         state_in.token_style    = start_style_in;
         state_in.token_inactive = start_inactive_in;
         state_in.swallow_next   = 1'b0;
         state_in.line_start     = 1'b1;
      end else if (req_take) begin
         state_in = step_state;
      end
   end

   // result register with skid entry
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (rsp_valid_ff && !rsp_pop) begin
            skid_in       = step_result;
            skid_valid_in = 1'b1;
         end else begin
            rsp_in       = step_result;
            rsp_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_style_ff    <= ST_DEFAULT;
         start_inactive_ff <= 1'b0;
         state_ff          <= '{token_style: ST_DEFAULT, token_inactive: 1'b0,
                                swallow_next: 1'b0, line_start: 1'b1};
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         start_style_ff    <= start_style_in;
         start_inactive_ff <= start_inactive_in;
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   // skid entry is only used behind a full result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds an item while result register is empty");

   // an item taken while the result stalls lands in the skid entry
   assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("item taken under stall was not kept in the skid entry");

   // a swallowed byte never arms swallowing again
   assert property (@(posedge clock) disable iff (reset)
      (req_take && !csr_write_enable && state_ff.swallow_next) |=> !state_ff.swallow_next)
      else $error("swallow flag survived a swallowed byte");

   // a register write restarts the lexer at line start
   assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (!state_ff.swallow_next && state_ff.line_start))
      else $error("register write did not restart the lexer state");

endmodule
